### src/mclp_pkg.sv
// mclp_pkg: types, codes and constants shared by the motor command line parser
// used by mclp_parser and motor_command_line_parser; no dependencies

`default_nettype none

package mclp_pkg;

  // field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SPEED_W   = 7;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned RESP_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned OUT_W     = 32;

  // reset values of the configuration registers, and the speed limit
  localparam logic [PERIOD_W-1:0] RESET_PERIOD        = 16'd999;
  localparam logic [SPEED_W-1:0]  RESET_DEFAULT_SPEED = 7'd30;
  localparam logic [SPEED_W-1:0]  SPEED_MAX           = 7'd100;

  // divide by 100 as (x >> 2) / 25, the latter by reciprocal multiply
  localparam int unsigned PROD_W     = SPEED_W + PERIOD_W;   // 23
  localparam int unsigned QUART_W    = PROD_W - 2;           // 21
  localparam int unsigned RECIP_W    = 22;
  localparam int unsigned RECIP_SH   = 26;
  localparam logic [RECIP_W-1:0] RECIP_25 = 22'd2684355;     // ceil(2^26 / 25)
  localparam int unsigned SCALED_W   = QUART_W + RECIP_W;    // 43

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PWM_PERIOD    = 1'b0,
    CFG_DEFAULT_SPEED = 1'b1
  } cfg_index_t;

  // response codes
  typedef enum logic [RESP_W-1:0] {
    RESP_OK      = 2'd0,
    RESP_OK_DEF  = 2'd1,
    RESP_OK_KEEP = 2'd2,
    RESP_ERR     = 2'd3
  } resp_t;

  // parser phases
  typedef enum logic [3:0] {
    PH_LEAD   = 4'd0,
    PH_O_UP   = 4'd1,
    PH_O_LO   = 4'd2,
    PH_OF_UP  = 4'd3,
    PH_OF_LO  = 4'd4,
    PH_S_UP   = 4'd5,
    PH_S_LO   = 4'd6,
    PH_SKIP1  = 4'd7,
    PH_SKIPSP = 4'd8,
    PH_DIGITS = 4'd9,
    PH_TRAIL  = 4'd10,
    PH_HOLD   = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    KW_NONE  = 2'd0,
    KW_ON    = 2'd1,
    KW_OFF   = 2'd2,
    KW_SPEED = 2'd3
  } keyword_t;

  // characters
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UP_O  = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_LO_O  = 8'h6F;
  localparam logic [BYTE_W-1:0] CH_UP_S  = 8'h53;
  localparam logic [BYTE_W-1:0] CH_LO_S  = 8'h73;
  localparam logic [BYTE_W-1:0] CH_UP_N  = 8'h4E;
  localparam logic [BYTE_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

  // result of one evaluated line, handed to the scaling pipeline
  typedef struct packed {
    resp_t               resp;
    logic [SPEED_W-1:0]  speed;
  } line_result_t;

  // upper case letters of the speed keyword
  function automatic logic [BYTE_W-1:0] speed_letter(input logic [2:0] idx);
    logic [BYTE_W-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h53;  // S
      3'd1:    ch = 8'h50;  // P
      3'd2:    ch = 8'h45;  // E
      3'd3:    ch = 8'h45;  // E
      default: ch = 8'h44;  // D
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

### src/mclp_parser.sv
// mclp_parser: per-byte command line state machine and motor speed register
// depends on mclp_pkg

`default_nettype none

module mclp_parser
  import mclp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [BYTE_W-1:0]  rx_byte,
  input  wire logic               line_end,
  input  wire logic [SPEED_W-1:0] default_speed,
  output line_result_t            result
);

  phase_t             phase, phase_next;
  keyword_t           keyword, keyword_next;
  logic [BYTE_W-1:0]  acc, acc_next;
  logic               line_error, line_error_next;
  logic [SPEED_W-1:0] motor_speed, motor_speed_next;

  logic [BYTE_W-1:0]  low;
  logic [BYTE_W-1:0]  digit;
  logic               is_digit;
  logic [SPEED_W-1:0] clamped_default;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit    = rx_byte - CH_ZERO;
  assign low      = (phase == PH_O_LO || phase == PH_OF_LO || phase == PH_S_LO) ?
                    CASE_BIT : '0;

  // next parse state
  always_comb begin
    phase_next      = phase;
    keyword_next    = keyword;
    acc_next        = acc;
    line_error_next = line_error;
    if (accept && line_end) begin
      phase_next      = PH_LEAD;
      keyword_next    = KW_NONE;
      acc_next        = '0;
      line_error_next = 1'b0;
    end else if (accept && phase != PH_HOLD) begin
      if (rx_byte == CH_NUL) begin
        // string terminator: rest of the line is ignored
        if (!(keyword == KW_ON || keyword == KW_OFF ||
              phase == PH_DIGITS || phase == PH_TRAIL)) begin
          line_error_next = 1'b1;
        end
        phase_next = PH_HOLD;
      end else begin
        case (phase)
          PH_LEAD: begin
            if (rx_byte == CH_SPACE) begin
              phase_next = PH_LEAD;
            end else if (rx_byte == CH_UP_O) begin
              phase_next = PH_O_UP;
            end else if (rx_byte == CH_LO_O) begin
              phase_next = PH_O_LO;
            end else if (rx_byte == CH_UP_S) begin
              acc_next   = 8'd1;
              phase_next = PH_S_UP;
            end else if (rx_byte == CH_LO_S) begin
              acc_next   = 8'd1;
              phase_next = PH_S_LO;
            end else begin
              line_error_next = 1'b1;
              phase_next      = PH_HOLD;
            end
          end
          PH_O_UP, PH_O_LO: begin
            if (rx_byte == (CH_UP_N | low)) begin
              keyword_next = KW_ON;
              phase_next   = PH_HOLD;
            end else if (rx_byte == (CH_UP_F | low)) begin
              phase_next = (phase == PH_O_LO) ? PH_OF_LO : PH_OF_UP;
            end else begin
              line_error_next = 1'b1;
              phase_next      = PH_HOLD;
            end
          end
          PH_OF_UP, PH_OF_LO: begin
            if (rx_byte == (CH_UP_F | low)) begin
              keyword_next = KW_OFF;
              phase_next   = PH_HOLD;
            end else begin
              line_error_next = 1'b1;
              phase_next      = PH_HOLD;
            end
          end
          PH_S_UP, PH_S_LO: begin
            // acc counts matched letters of the keyword
            if (acc >= 8'd5 || rx_byte != (speed_letter(acc[2:0]) | low)) begin
              line_error_next = 1'b1;
              phase_next      = PH_HOLD;
            end else if (acc == 8'd4) begin
              keyword_next = KW_SPEED;
              acc_next     = '0;
              phase_next   = PH_SKIP1;
            end else begin
              acc_next = acc + 8'd1;
            end
          end
          PH_SKIP1: begin
            phase_next = PH_SKIPSP;
          end
          PH_SKIPSP: begin
            if (rx_byte == CH_SPACE) begin
              phase_next = PH_SKIPSP;
            end else if (is_digit) begin
              acc_next   = digit;
              phase_next = PH_DIGITS;
            end else begin
              line_error_next = 1'b1;
              phase_next      = PH_HOLD;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              // value kept modulo 256
              acc_next = {acc[4:0], 3'b000} + {acc[6:0], 1'b0} + digit;
            end else if (rx_byte == CH_SPACE) begin
              phase_next = PH_TRAIL;
            end else begin
              line_error_next = 1'b1;
              phase_next      = PH_HOLD;
            end
          end
          PH_TRAIL: begin
            if (rx_byte != CH_SPACE) begin
              line_error_next = 1'b1;
              phase_next      = PH_HOLD;
            end
          end
          default: begin
            line_error_next = 1'b1;
            phase_next      = PH_HOLD;
          end
        endcase
      end
    end
  end

  // line evaluation at end of line
  assign clamped_default = (default_speed > SPEED_MAX) ? SPEED_MAX : default_speed;

  always_comb begin
    result.resp      = RESP_ERR;
    motor_speed_next = motor_speed;
    if (!line_error && keyword == KW_ON) begin
      if (motor_speed == '0) begin
        motor_speed_next = clamped_default;
        result.resp      = RESP_OK_DEF;
      end else begin
        result.resp = RESP_OK_KEEP;
      end
    end else if (!line_error && keyword == KW_OFF) begin
      motor_speed_next = '0;
      result.resp      = RESP_OK;
    end else if (!line_error && keyword == KW_SPEED &&
                 (phase inside {PH_DIGITS, PH_TRAIL, PH_HOLD}) &&
                 acc <= 8'd100) begin
      motor_speed_next = acc[SPEED_W-1:0];
      result.resp      = RESP_OK;
    end
    result.speed = motor_speed_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      keyword     <= KW_NONE;
      acc         <= '0;
      line_error  <= 1'b0;
      motor_speed <= '0;
    end else begin
      phase      <= phase_next;
      keyword    <= keyword_next;
      acc        <= acc_next;
      line_error <= line_error_next;
      if (accept && line_end) begin
        motor_speed <= motor_speed_next;
      end
    end
  end

endmodule

`default_nettype wire

### src/motor_command_line_parser.sv
// motor_command_line_parser: top level, config registers and pwm scaling pipeline
// depends on mclp_pkg and mclp_parser
// path: a result passes the stage 1, stage 2 and output registers after the item that ends its line
// throughput: one item per cycle; ready drops only when all three result
// stages are full and the output is stalled
// reset: rst synchronous active high; period 999, default speed 30, motor stopped

`default_nettype none

module motor_command_line_parser
  import mclp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // command bytes
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
  input  wire logic                 s_tlast,   // line_end
  // responses
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [OUT_W-1:0]          m_tdata    // [1:0] response, [8:2] speed_percent,
                                               // [24:9] compare_value, [25] drive_on
);

  logic [PERIOD_W-1:0] timer_period;
  logic [SPEED_W-1:0]  default_speed;

  logic         accept;
  line_result_t line_res;

  logic               adv1, adv2, adv3;
  logic               s1_valid;
  line_result_t       s1_res;
  logic               s2_valid;
  line_result_t       s2_res;
  logic [PROD_W-1:0]  s2_prod;
  logic [SCALED_W-1:0] scaled;

  resp_t               out_resp;
  logic [SPEED_W-1:0]  out_speed;
  logic [PERIOD_W-1:0] out_compare;
  logic                out_drive;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period  <= RESET_PERIOD;
      default_speed <= RESET_DEFAULT_SPEED;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PWM_PERIOD:    timer_period  <= cfg_data;
        CFG_DEFAULT_SPEED: default_speed <= cfg_data[SPEED_W-1:0];
        default:           timer_period  <= timer_period;
      endcase
    end
  end

  // stage advance, bubbles collapse
  assign adv3     = !m_tvalid || m_tready;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign s_tready = adv1;
  assign accept   = s_tvalid && s_tready;

  mclp_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .rx_byte       (s_tdata),
    .line_end      (s_tlast),
    .default_speed (default_speed),
    .result        (line_res)
  );

  // stage 1: evaluated line
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= accept && s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_res <= line_res;
    end
  end

  // stage 2: speed times period
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_res  <= s1_res;
      s2_prod <= PROD_W'(s1_res.speed) * PROD_W'(timer_period);
    end
  end

  // stage 3: divide by 100 as quarter times reciprocal of 25
  assign scaled = SCALED_W'(s2_prod[PROD_W-1:2]) * SCALED_W'(RECIP_25);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv3) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      out_resp    <= s2_res.resp;
      out_speed   <= s2_res.speed;
      out_compare <= scaled[RECIP_SH+PERIOD_W-1:RECIP_SH];
      out_drive   <= (s2_res.speed != '0);
    end
  end

  // output packing
  assign m_tdata = {6'b000000, out_drive, out_compare, out_speed, out_resp};

  // checks
  a_drive_matches_speed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_drive == (out_speed != '0)))
    else $error("drive flag disagrees with speed");

  a_speed_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_speed <= SPEED_MAX))
    else $error("speed above 100");

  a_stopped_compare_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_speed == '0) |-> (out_compare == '0))
    else $error("compare nonzero while stopped");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && s2_valid && m_tvalid && !m_tready))
    else $error("input stalled with room in pipeline");

endmodule

`default_nettype wire
